// ----- rtl/afi_pkg.sv -----
// Package for the arming failsafe interlock: item and configuration types,
// operation and register codes, and reset constants. No dependencies.
package afi_pkg;

  // Switch channel full scale and the armed fraction used at reset.
  localparam int unsigned SwitchFullScale = 2047;
  localparam int unsigned ArmedPercent    = 90;
  localparam logic [10:0] THRESHOLD_RESET = 11'(SwitchFullScale * ArmedPercent / 100);
  localparam logic [31:0] TIMEOUT_RESET   = 32'd5000;
  localparam logic [15:0] LIMIT_RESET     = 16'd3;
  localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

  localparam int unsigned ADDR_W = 4;

  typedef enum logic [1:0] {
    MODE_SET   = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_EVAL  = 2'd2,
    MODE_HOLD  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_THRESHOLD = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_LIMIT     = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t       mode;
    logic [2:0]  reason;
    logic [10:0] arm_value;
    logic        arm_valid;
    logic [10:0] prearm_value;
    logic        prearm_valid;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [10:0] switch_threshold;
    logic [31:0] rearm_timeout_ms;
    logic [15:0] repeat_limit;
  } cfg_t;

endpackage

// ----- rtl/afi_cfg.sv -----
// Configuration register file of the arming failsafe interlock, APB-style port.
// Depends on afi_pkg.
module afi_cfg
  import afi_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.switch_threshold <= THRESHOLD_RESET;
      cfg.rearm_timeout_ms <= TIMEOUT_RESET;
      cfg.repeat_limit     <= LIMIT_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_THRESHOLD: cfg.switch_threshold <= pwdata[10:0];
        REG_TIMEOUT:   cfg.rearm_timeout_ms <= pwdata;
        REG_LIMIT:     cfg.repeat_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD: prdata = {21'b0, cfg.switch_threshold};
      REG_TIMEOUT:   prdata = cfg.rearm_timeout_ms;
      REG_LIMIT:     prdata = {16'b0, cfg.repeat_limit};
      default:       prdata = 32'b0;
    endcase
  end

endmodule

// ----- rtl/afi_core.sv -----
// Interlock state and the single-pass update for one item.
// Depends on afi_pkg.
module afi_core
  import afi_pkg::*;
#(
  parameter int unsigned REASON_BITS     = 8,
  parameter int unsigned BIT_BOOT        = 0,
  parameter int unsigned BIT_ARM_SWITCH  = 1,
  parameter int unsigned BIT_DISARM_WAIT = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  item_t                  item,
  input  cfg_t                   cfg,
  output logic [REASON_BITS-1:0] mask_q,
  output logic [REASON_BITS-1:0] mask_next
);

  typedef struct packed {
    logic [REASON_BITS-1:0] mask;
    logic [31:0]            entry_time;
    logic                   timeout_expired;
    logic [15:0]            entry_count;
    logic                   repeat_forced;
    logic                   prearm_seen_first;
    logic                   both_released;
  } st_t;

  // Reason index outside the mask maps to no bit.
  function automatic logic [REASON_BITS-1:0] bit_of(input int unsigned idx);
    logic [REASON_BITS-1:0] b;
    b = '0;
    if (idx < REASON_BITS) b = {{(REASON_BITS-1){1'b0}}, 1'b1} << idx;
    return b;
  endfunction

  // Set a reason bit; on entry into failsafe stamp time and count the entry.
  function automatic st_t raise(input st_t s, input logic [REASON_BITS-1:0] b,
                                input logic [31:0] now);
    st_t r;
    r = s;
    if (b != '0 && (s.mask & b) == '0) begin
      if (s.mask == '0) begin
        r.entry_time      = now;
        r.timeout_expired = 1'b0;
        if (s.entry_count != COUNT_MAX) r.entry_count = s.entry_count + 16'd1;
      end
      r.mask = s.mask | b;
    end
    return r;
  endfunction

  localparam logic [REASON_BITS-1:0] BootBit  = bit_of(BIT_BOOT);
  localparam logic [REASON_BITS-1:0] ArmBit   = bit_of(BIT_ARM_SWITCH);
  localparam logic [REASON_BITS-1:0] WaitBit  = bit_of(BIT_DISARM_WAIT);

  st_t  st, st_next;
  logic arm_on, pre_on;

  assign arm_on = item.arm_valid && (item.arm_value > cfg.switch_threshold);
  assign pre_on = item.prearm_valid && (item.prearm_value > cfg.switch_threshold);

  always_comb begin
    st_next = st;
    case (item.mode)
      MODE_SET:   st_next = raise(st, bit_of(32'(item.reason)), item.now_ms);
      MODE_CLEAR: st_next.mask = st.mask & ~bit_of(32'(item.reason));
      MODE_EVAL: begin
        if (st.both_released && st.prearm_seen_first && pre_on && arm_on) begin
          st_next.mask          = st_next.mask & ~ArmBit;
          st_next.both_released = 1'b0;
        end else if (!arm_on) begin
          st_next = raise(st_next, ArmBit, item.now_ms);
        end
        if (!st_next.timeout_expired && st_next.mask != '0 &&
            (item.now_ms - st_next.entry_time) > cfg.rearm_timeout_ms) begin
          st_next                 = raise(st_next, WaitBit, item.now_ms);
          st_next.timeout_expired = 1'b1;
        end
        if (!st_next.repeat_forced && st_next.mask != '0 &&
            st_next.entry_count > cfg.repeat_limit) begin
          st_next               = raise(st_next, WaitBit, item.now_ms);
          st_next.repeat_forced = 1'b1;
        end
        if (item.arm_valid && !arm_on) begin
          st_next.mask          = st_next.mask & ~WaitBit;
          st_next.entry_count   = '0;
          st_next.repeat_forced = 1'b0;
        end
        st_next.prearm_seen_first = pre_on && !arm_on;
        if (!pre_on && !arm_on) st_next.both_released = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mask              <= BootBit | WaitBit;
      st.entry_time        <= '0;
      st.timeout_expired   <= 1'b0;
      st.entry_count       <= '0;
      st.repeat_forced     <= 1'b0;
      st.prearm_seen_first <= 1'b0;
      st.both_released     <= 1'b0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  assign mask_q    = st.mask;
  assign mask_next = st_next.mask;

endmodule

// ----- rtl/arming_failsafe_interlock_core.sv -----
// Top level of the motor-arming failsafe interlock: input stage, state core,
// result register and configuration port. Depends on afi_pkg, afi_cfg, afi_core.
//
//   channel  | handshake                          | payload
//   ---------+------------------------------------+-----------------------------------
//   input    | in_valid / in_ready                | mode, reason, arm_value, arm_valid,
//            |                                    | prearm_value, prearm_valid, now_ms
//   result   | out_valid / out_ready              | failsafe_mask, failsafe_active
//   config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// One item per cycle sustained while the result is not stalled: each transfer lands in
// the input register, then runs through the state update and loads the result register,
// which raises result valid once the result register is free or being drained.
// Synchronous active-high reset clears the valid flags, the interlock state (boot and
// disarm-wait reasons raised) and restores the configuration defaults.
// A stalled result holds the input register; in_ready drops only while both stages
// are full and out_ready is low.
module arming_failsafe_interlock_core
  import afi_pkg::*;
#(
  parameter int unsigned REASON_BITS     = 8,
  parameter int unsigned BIT_BOOT        = 0,
  parameter int unsigned BIT_ARM_SWITCH  = 1,
  parameter int unsigned BIT_DISARM_WAIT = 2
) (
  input  logic              clk,
  input  logic              rst,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [2:0]        reason,
  input  logic [10:0]       arm_value,
  input  logic              arm_valid,
  input  logic [10:0]       prearm_value,
  input  logic              prearm_valid,
  input  logic [31:0]       now_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        failsafe_mask,
  output logic              failsafe_active,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t                   cfg;
  item_t                  iq_item;
  logic                   iq_valid;
  logic                   advance;
  logic [REASON_BITS-1:0] mask_q;
  logic [REASON_BITS-1:0] mask_next;
  logic [REASON_BITS+7:0] mask_ext;

  afi_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Advance the held item whenever the result register is free or being drained.
  assign advance  = iq_valid && (!out_valid || out_ready);
  assign in_ready = !iq_valid || advance;

  // Input register: take a transfer, drop the item once it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      iq_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      iq_valid <= 1'b1;
    end else if (advance) begin
      iq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      iq_item.mode         <= mode_t'(mode);
      iq_item.reason       <= reason;
      iq_item.arm_value    <= arm_value;
      iq_item.arm_valid    <= arm_valid;
      iq_item.prearm_value <= prearm_value;
      iq_item.prearm_valid <= prearm_valid;
      iq_item.now_ms       <= now_ms;
    end
  end

  // State update; the core commits its state on the same edge as the result.
  afi_core #(
    .REASON_BITS     (REASON_BITS),
    .BIT_BOOT        (BIT_BOOT),
    .BIT_ARM_SWITCH  (BIT_ARM_SWITCH),
    .BIT_DISARM_WAIT (BIT_DISARM_WAIT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (iq_item),
    .cfg       (cfg),
    .mask_q    (mask_q),
    .mask_next (mask_next)
  );

  // Report only the low byte of the mask; active looks at every reason bit.
  assign mask_ext = {8'b0, mask_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      failsafe_mask   <= mask_ext[7:0];
      failsafe_active <= |mask_next;
    end
  end

  // Any visible reason bit means motors are off.
  a_active_covers_mask: assert property (@(posedge clk) disable iff (rst)
    (out_valid && failsafe_mask != 8'b0) |-> failsafe_active)
    else $error("failsafe_active low with reason bits shown");

  // A full pipeline facing a stalled result must not take another transfer.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (iq_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input stage overrun while result stalled");

  // A no-change item leaves the mask untouched.
  a_hold_keeps_mask: assert property (@(posedge clk) disable iff (rst)
    (advance && iq_item.mode == MODE_HOLD) |-> (mask_next == mask_q))
    else $error("no-change item altered the reason mask");

  // A clear item never raises a reason.
  a_clear_no_raise: assert property (@(posedge clk) disable iff (rst)
    (advance && iq_item.mode == MODE_CLEAR) |-> ((mask_next & ~mask_q) == '0))
    else $error("clear item raised a reason bit");

endmodule
